### hdl/pwcc_pkg.sv
// Package for the path/wall crossing check: wall and segment types, arithmetic
// widths and operation codes. No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package pwcc_pkg;

  localparam int COORD_W  = 16;  // signed Q8.8 coordinate
  localparam int DIFF_W   = 17;  // difference of two coordinates
  localparam int PROD_W   = 34;  // product of two differences
  localparam int CROSS_W  = 35;  // difference of two products
  localparam int INDEX_W  = 6;   // wall index field
  localparam int COUNT_W  = 7;   // wall_count register

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One stored wall: start and end point.
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } wall_t;

  // The path under test: start point and direction.
  typedef struct packed {
    logic signed [COORD_W-1:0] p0x;
    logic signed [COORD_W-1:0] p0y;
    logic signed [DIFF_W-1:0]  rx;
    logic signed [DIFF_W-1:0]  ry;
  } seg_t;

  // A wall presented to the tester.
  typedef struct packed {
    logic  valid;
    wall_t wall;
  } probe_t;

  // Verdict of the tester for one wall.
  typedef struct packed {
    logic valid;
    logic hit;
  } hit_t;

endpackage

`default_nettype wire

### hdl/pwcc_if.sv
// Valid/ready channel interfaces for the path/wall crossing check: the item
// channel into the block and the result channel out of it. Uses pwcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pwcc_in_if;
  import pwcc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [INDEX_W-1:0]        index;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (
    output valid, opcode, index, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, index, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface pwcc_out_if;
  logic valid;
  logic ready;
  logic path_clear;

  modport source (output valid, path_clear, input ready);
  modport sink (input valid, path_clear, output ready);
endinterface

`default_nettype wire

### hdl/pwcc_cell.sv
// One cell of the wall ring: holds a single wall, loads it on a write and
// passes it to its neighbor while the ring rotates. Uses pwcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwcc_cell (
  input  wire             clk_i,
  input  wire             load_i,
  input  pwcc_pkg::wall_t wall_i,
  input  wire             shift_i,
  input  pwcc_pkg::wall_t nbr_i,
  output pwcc_pkg::wall_t wall_o
);
  import pwcc_pkg::*;

  wall_t wall_q;
  wall_t wall_d;

  always_comb begin
    priority if (load_i) begin
      wall_d = wall_i;
    end else if (shift_i) begin
      wall_d = nbr_i;
    end else begin
      wall_d = wall_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wall_q <= wall_d;
  end

  assign wall_o = wall_q;

endmodule

`default_nettype wire

### hdl/pwcc_seg_test.sv
// Pipelined segment intersection tester: differences, six products, three
// cross products, then the endpoint-inclusive range check. Uses pwcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwcc_seg_test (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  pwcc_pkg::probe_t probe_i,
  input  pwcc_pkg::seg_t   seg_i,
  output pwcc_pkg::hit_t   res_o
);
  import pwcc_pkg::*;

  // Stage 1: direction of the wall and offset between the start points.
  logic                     v1_q;
  logic signed [DIFF_W-1:0] sx_q, sy_q, wx_q, wy_q;
  // Stage 2: products.
  logic                     v2_q;
  logic signed [PROD_W-1:0] rs_q, rs2_q, ws_q, ws2_q, wr_q, wr2_q;
  // Stage 3: cross products d, t and u.
  logic                      v3_q;
  logic signed [CROSS_W-1:0] d_q, t_q, u_q;

  logic t_pos, t_neg, u_pos, u_neg, d_zero, in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= probe_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q  <= DIFF_W'(probe_i.wall.ex) - DIFF_W'(probe_i.wall.sx);
    sy_q  <= DIFF_W'(probe_i.wall.ey) - DIFF_W'(probe_i.wall.sy);
    wx_q  <= DIFF_W'(probe_i.wall.sx) - DIFF_W'(seg_i.p0x);
    wy_q  <= DIFF_W'(probe_i.wall.sy) - DIFF_W'(seg_i.p0y);

    rs_q  <= PROD_W'(seg_i.rx) * PROD_W'(sy_q);
    rs2_q <= PROD_W'(seg_i.ry) * PROD_W'(sx_q);
    ws_q  <= PROD_W'(wx_q) * PROD_W'(sy_q);
    ws2_q <= PROD_W'(wy_q) * PROD_W'(sx_q);
    wr_q  <= PROD_W'(wx_q) * PROD_W'(seg_i.ry);
    wr2_q <= PROD_W'(wy_q) * PROD_W'(seg_i.rx);

    d_q   <= CROSS_W'(rs_q) - CROSS_W'(rs2_q);
    t_q   <= CROSS_W'(ws_q) - CROSS_W'(ws2_q);
    u_q   <= CROSS_W'(wr_q) - CROSS_W'(wr2_q);
  end

  // Both parameters must lie between 0 and d inclusive; for a negative d the
  // bounds flip instead of negating all three values.
  always_comb begin
    d_zero = (d_q == '0);
    t_pos  = !t_q[CROSS_W-1];
    t_neg  = t_q[CROSS_W-1] || (t_q == '0);
    u_pos  = !u_q[CROSS_W-1];
    u_neg  = u_q[CROSS_W-1] || (u_q == '0);
    if (!d_q[CROSS_W-1]) begin
      in_range = t_pos && (t_q <= d_q) && u_pos && (u_q <= d_q);
    end else begin
      in_range = t_neg && (t_q >= d_q) && u_neg && (u_q >= d_q);
    end
  end

  assign res_o.valid = v3_q;
  assign res_o.hit   = !d_zero && in_range;

endmodule

`default_nettype wire

### hdl/path_wall_crossing_check_unit.sv
// Top level of the path/wall crossing check: configuration register, wall ring
// of pwcc_cell instances, pwcc_seg_test tester and result buffering.
// Depends on pwcc_pkg, pwcc_in_if / pwcc_out_if, pwcc_cell and pwcc_seg_test.
`timescale 1ns / 1ps
`default_nettype none

// The block stores up to MAX_WALLS 2D wall segments in a ring of cells and
// answers whether a path segment crosses any of walls 0 to wall_count-1
// (endpoints touching counts as a crossing; parallel, collinear and zero-length
// pairs never cross). Coordinates are signed Q8.8 and the test is exact.
// A write item (opcode 0) loads one cell and its result (path_clear = 1) is
// produced at acceptance; a write to an index at or above MAX_WALLS changes
// nothing. A query item (opcode 1) rotates the ring once, presenting one wall
// per cycle to a single tester, so a query always runs a full rotation of
// the ring, whatever wall_count is. Only one item is in work at a time, but a
// finished result may wait in the output buffer while the next item is
// accepted and worked on. A wall_count above MAX_WALLS tests all MAX_WALLS
// walls. Walls hold no reset value; a query must only reach walls that have
// been written. The wall_count register may be written only while no item is
// in work.
module path_wall_crossing_check_unit #(
  parameter int MAX_WALLS = 64
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [pwcc_pkg::COUNT_W-1:0]     cfg_wdata_i,
  pwcc_in_if.sink                          req_i,
  pwcc_out_if.source                       rsp_o
);
  import pwcc_pkg::*;

  localparam int CNT_W = $clog2(MAX_WALLS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Last value of the drain counter: the tester depth minus one.
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [COUNT_W-1:0] wall_count_q;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] pos_q, pos_d;    // ring rotation steps so far
  logic [CNT_W-1:0] limit_q, limit_d; // number of walls this query tests
  logic [1:0]       drain_q, drain_d;
  logic             crossed_q, crossed_d;
  seg_t             seg_q;

  logic out_valid_q, out_clear_q;
  logic pend_q, pend_clear_q;

  logic   accept, acc_write, acc_query;
  logic   shift;
  logic   produce, produce_clear;
  logic   take;
  wall_t  wr_wall;
  wall_t  ring [MAX_WALLS];
  probe_t probe;
  hit_t   res;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_count_q <= '0;
    end else if (cfg_we_i) begin
      wall_count_q <= cfg_wdata_i;
    end
  end

  // A new item is taken when nothing is in work and the spare result slot is
  // free; the output register itself may still be full.
  assign req_i.ready = (state_q == ST_IDLE) && !pend_q;
  assign accept      = req_i.valid && req_i.ready;
  assign acc_write   = accept && (req_i.opcode == OP_WRITE);
  assign acc_query   = accept && (req_i.opcode == OP_QUERY);
  assign shift       = (state_q == ST_SCAN);

  assign wr_wall = '{sx: req_i.start_x, sy: req_i.start_y,
                     ex: req_i.end_x,   ey: req_i.end_y};

  // Ring of wall cells. Cell 0 is the head that feeds the tester; during a
  // query every cell takes its upper neighbor's wall, so after MAX_WALLS
  // steps every wall is back in its home cell.
  for (genvar gi = 0; gi < MAX_WALLS; gi++) begin : g_cell
    localparam int NXT = (gi + 1) % MAX_WALLS;
    logic load;

    assign load = acc_write && (32'(req_i.index) == 32'(gi));

    pwcc_cell u_cell (
      .clk_i  (clk_i),
      .load_i (load),
      .wall_i (wr_wall),
      .shift_i(shift),
      .nbr_i  (ring[NXT]),
      .wall_o (ring[gi])
    );
  end

  // At rotation step k the head holds wall k.
  assign probe.valid = shift && (pos_q < limit_q);
  assign probe.wall  = ring[0];

  pwcc_seg_test u_test (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .probe_i(probe),
    .seg_i  (seg_q),
    .res_o  (res)
  );

  // Sequencer: idle, rotate the ring, then let the tester pipeline empty.
  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    limit_d       = limit_q;
    drain_d       = drain_q;
    crossed_d     = crossed_q | (res.valid & res.hit);
    produce       = 1'b0;
    produce_clear = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_write) begin
          produce = 1'b1;
        end else if (acc_query) begin
          state_d   = ST_SCAN;
          pos_d     = '0;
          crossed_d = 1'b0;
          if (32'(wall_count_q) > 32'(MAX_WALLS)) begin
            limit_d = CNT_W'(MAX_WALLS);
          end else begin
            limit_d = CNT_W'(wall_count_q);
          end
        end
      end
      ST_SCAN: begin
        if (pos_q == CNT_W'(MAX_WALLS - 1)) begin
          state_d = ST_DRAIN;
          pos_d   = '0;
          drain_d = '0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_q == DRAIN_LAST) begin
          // The verdict on the last wall arrives in this cycle.
          produce       = 1'b1;
          produce_clear = !crossed_d;
          state_d       = ST_IDLE;
        end else begin
          drain_d = drain_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      limit_q   <= '0;
      drain_q   <= '0;
      crossed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      limit_q   <= limit_d;
      drain_q   <= drain_d;
      crossed_q <= crossed_d;
    end
  end

  // The path under test is captured once at acceptance.
  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      seg_q.p0x <= req_i.start_x;
      seg_q.p0y <= req_i.start_y;
      seg_q.rx  <= DIFF_W'(req_i.end_x) - DIFF_W'(req_i.start_x);
      seg_q.ry  <= DIFF_W'(req_i.end_y) - DIFF_W'(req_i.start_y);
    end
  end

  // Output register plus one spare slot. A result that finds the output
  // register full and not being taken parks in the spare slot, which blocks
  // further items until it has moved on.
  assign take = out_valid_q && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (take || !out_valid_q) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= produce;
      end
    end else if (produce) begin
      pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_valid_q) begin
      out_clear_q <= pend_q ? pend_clear_q : produce_clear;
    end
    if (produce) begin
      pend_clear_q <= produce_clear;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.path_clear = out_clear_q;

  // After a write is accepted, the output register always holds a result in the next cycle.
  a_write_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_write |=> rsp_o.valid)
    else $error("write item did not produce a result");

  // The spare slot is only ever used behind a full output register.
  a_pend_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("spare result slot full while output register empty");

  // The last rotation step always leads into the drain phase.
  a_scan_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && pos_q == CNT_W'(MAX_WALLS - 1)) |=> state_q == ST_DRAIN)
    else $error("ring rotation did not end after MAX_WALLS steps");

  // The tester only reports while a query is in work.
  a_hit_in_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("tester verdict outside a query");

  // A new query starts with no crossing recorded.
  a_query_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_query |=> !crossed_q)
    else $error("crossing flag not cleared at query start");

endmodule

`default_nettype wire

### tb/path_wall_crossing_check_unit_test.sv
// Testbench for path_wall_crossing_check_unit: wall writes and path queries are
// checked one by one against a cycle-free model of the wall table and crossing test.
// Depends on pwcc_pkg, pwcc_in_if and pwcc_out_if from the RTL.
`timescale 1ns / 1ps

package pwcc_tb_pkg;
  import pwcc_pkg::*;

  localparam int WALL_SLOTS   = 64;
  // Room for the verdicts of items that are accepted but not yet answered.
  localparam int EXPECT_DEPTH = 16;

  // One item on the request channel.
  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] idx;
    wall_t              seg;
  } wall_item_t;

  // Keeps a shadow of the wall table and the wall_count register, predicts
  // path_clear for every accepted item and checks results in order.
  class crossing_scoreboard;
    wall_t              wall_shadow[WALL_SLOTS];
    logic [COUNT_W-1:0] wall_count;
    bit                 clear_expected[EXPECT_DEPTH];
    int                 exp_head;
    int                 exp_tail;
    int                 mismatches;
    int                 results_seen;

    function new();
      foreach (wall_shadow[i]) wall_shadow[i] = '0;
      foreach (clear_expected[i]) clear_expected[i] = 1'b0;
      wall_count   = '0;
      exp_head     = 0;
      exp_tail     = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Exact cross-product test; touching endpoints meet, parallel pairs never do.
    function bit crosses(wall_t path, wall_t wall);
      longint prx, pry, wdx, wdy, ox, oy, den, t_num, u_num;
      prx = longint'(path.ex) - longint'(path.sx);
      pry = longint'(path.ey) - longint'(path.sy);
      wdx = longint'(wall.ex) - longint'(wall.sx);
      wdy = longint'(wall.ey) - longint'(wall.sy);
      ox  = longint'(wall.sx) - longint'(path.sx);
      oy  = longint'(wall.sy) - longint'(path.sy);
      den = prx * wdy - pry * wdx;
      if (den == 0) return 1'b0;
      t_num = ox * wdy - oy * wdx;
      u_num = ox * pry - oy * prx;
      if (den < 0) begin
        den   = -den;
        t_num = -t_num;
        u_num = -u_num;
      end
      return t_num >= 0 && t_num <= den && u_num >= 0 && u_num <= den;
    endfunction

    function bit path_is_clear(wall_t path);
      int tested;
      tested = (wall_count > WALL_SLOTS) ? WALL_SLOTS : int'(wall_count);
      for (int i = 0; i < tested; i++) begin
        if (crosses(path, wall_shadow[i])) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Appends one predicted verdict behind those still waiting.
    function void add_expected(bit want);
      clear_expected[exp_tail % EXPECT_DEPTH] = want;
      exp_tail++;
    endfunction

    function void note_item(wall_item_t item);
      if (item.op == OP_WRITE) begin
        wall_shadow[item.idx] = item.seg;
        add_expected(1'b1);
      end else begin
        add_expected(path_is_clear(item.seg));
      end
    endfunction

    function void check_result(logic got);
      bit want;
      results_seen++;
      if (exp_tail == exp_head) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected (path_clear %b)",
                   results_seen, got);
        return;
      end
      want = clear_expected[exp_head % EXPECT_DEPTH];
      exp_head++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: path_clear expected %b, got %b", results_seen, want, got);
      end
    endfunction

    function int pending();
      return exp_tail - exp_head;
    endfunction
  endclass

endpackage

// The run has two parts. A short directed part writes a few hand-placed
// walls and sends paths that cross, touch at an endpoint, run parallel or
// collinear, have zero length or stand vertical. Then twelve random phases
// follow, each after a wall_count write made while the block is idle. The
// first random phase fills the whole wall table in index order, so that later
// phases may set wall_count anywhere up to its 7-bit maximum without a query
// ever reaching an entry that was never written.
module path_wall_crossing_check_unit_test;
  import pwcc_pkg::*;
  import pwcc_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 121;
  localparam int TAIL_CYCLES   = WALL_SLOTS + 16;
  localparam int MAX_IDLE      = 18;

  // wall_count for each random phase; phases 8 and 9 draw a random value.
  localparam int PHASE_COUNTS[RANDOM_PHASES] =
    '{1, 64, 127, 0, 65, 2, 33, 63, 0, 0, 64, 127};

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;

  pwcc_in_if  req_if ();
  pwcc_out_if rsp_if ();

  path_wall_crossing_check_unit #(
    .MAX_WALLS (WALL_SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  crossing_scoreboard sb = new();

  // When set, the sender or the receiver runs without any idle cycles.
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  int cycle_count   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic int offset_in(int span);
    return int'($urandom_range(2 * span, 0)) - span;
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(3, 0))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic wall_item_t item_of(logic op, int idx, int sx, int sy, int ex, int ey);
    wall_item_t item;
    item.op     = op;
    item.idx    = INDEX_W'(idx);
    item.seg.sx = 16'(sx);
    item.seg.sy = 16'(sy);
    item.seg.ex = 16'(ex);
    item.seg.ey = 16'(ey);
    return item;
  endfunction

  // A free segment. Most are short and lie near the origin so that walls and
  // paths meet often; the rest cover the whole coordinate range, the extreme
  // values, axis-parallel and zero-length shapes.
  function automatic wall_t make_segment();
    wall_t s;
    int cx, cy, hx, hy;
    cx = offset_in(6000);
    cy = offset_in(6000);
    hx = offset_in(1500);
    hy = offset_in(1500);
    s.sx = clip16(cx - hx);
    s.sy = clip16(cy - hy);
    s.ex = clip16(cx + hx);
    s.ey = clip16(cy + hy);
    case ($urandom_range(9, 0))
      0: begin
        s.sx = 16'($urandom());
        s.sy = 16'($urandom());
        s.ex = 16'($urandom());
        s.ey = 16'($urandom());
      end
      1: begin
        s.sx = extreme_coord();
        s.sy = extreme_coord();
        s.ex = extreme_coord();
        s.ey = extreme_coord();
      end
      2: s.ex = s.sx;
      3: s.ey = s.sy;
      4: begin
        s.ex = s.sx;
        s.ey = s.sy;
      end
      default: ;
    endcase
    return s;
  endfunction

  // A query path, mostly built around one of the walls under test: through its
  // middle, from one of its endpoints, shifted beside it, along its own line,
  // or just missing an endpoint.
  function automatic wall_t make_path();
    wall_t w, p;
    int tested, mx, my, ox, oy, span;
    tested = (sb.wall_count > WALL_SLOTS) ? WALL_SLOTS : int'(sb.wall_count);
    w  = sb.wall_shadow[(tested == 0) ? 0 : $urandom_range(tested - 1, 0)];
    mx = (int'(w.sx) + int'(w.ex)) / 2;
    my = (int'(w.sy) + int'(w.ey)) / 2;
    span = ($urandom_range(1, 0) != 0) ? 16 : 2000;
    ox = offset_in(span);
    oy = offset_in(span);
    p  = w;
    case ($urandom_range(9, 0))
      0, 1: p = make_segment();
      2: begin
        // Starts exactly on an endpoint of the wall.
        if ($urandom_range(1, 0) != 0) begin
          p.sx = w.ex;
          p.sy = w.ey;
        end
        p.ex = clip16(int'(p.sx) + ox);
        p.ey = clip16(int'(p.sy) + oy);
      end
      3, 4: begin
        p.sx = clip16(mx + ox);
        p.sy = clip16(my + oy);
        p.ex = clip16(mx - ox);
        p.ey = clip16(my - oy);
      end
      5: begin
        p.sx = clip16(int'(w.sx) + ox);
        p.sy = clip16(int'(w.sy) + oy);
        p.ex = clip16(int'(w.ex) + ox);
        p.ey = clip16(int'(w.ey) + oy);
      end
      6: begin
        // Same line as the wall: reversed, or continuing past its end.
        if ($urandom_range(1, 0) != 0) begin
          p.sx = w.ex;
          p.sy = w.ey;
          p.ex = w.sx;
          p.ey = w.sy;
        end else begin
          p.sx = w.ex;
          p.sy = w.ey;
          p.ex = clip16(2 * int'(w.ex) - int'(w.sx));
          p.ey = clip16(2 * int'(w.ey) - int'(w.sy));
        end
      end
      7: begin
        p.sx = clip16(int'(w.sx) + offset_in(2));
        p.sy = clip16(int'(w.sy) + offset_in(2));
        p.ex = clip16(int'(p.sx) + ox);
        p.ey = clip16(int'(p.sy) + oy);
      end
      8: begin
        p.sx = clip16(mx);
        p.sy = clip16(my);
        p.ex = p.sx;
        p.ey = p.sy;
      end
      default: begin
        p.sx = clip16(mx);
        p.sy = clip16(my);
        p.ex = clip16(mx + ox);
        p.ey = clip16(my + oy);
      end
    endcase
    return p;
  endfunction

  // Offers one item after a random gap and returns at the edge where it is
  // taken. valid is only lowered when a gap follows, so back-to-back items
  // keep it high without a glitch.
  task automatic send_item(input wall_item_t item);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(MAX_IDLE, 0);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= item.op;
    req_if.index   <= item.idx;
    req_if.start_x <= item.seg.sx;
    req_if.start_y <= item.seg.sy;
    req_if.end_x   <= item.seg.ex;
    req_if.end_y   <= item.seg.ey;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_item(item);
  endtask

  // Stops offering items until every expected result has been taken.
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // wall_count is only changed while the block has nothing in work.
  task automatic write_wall_count(input logic [COUNT_W-1:0] value);
    hold_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.wall_count = value;
    cfg_we_i <= 1'b0;
  endtask

  // Result side: a random stall before each result, none in calm phases.
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(MAX_IDLE, 0);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_result(rsp_if.path_clear);
    end
  end

  initial begin
    wall_item_t item;
    logic [COUNT_W-1:0] count;
    int fill_next;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    req_if.valid   <= 1'b0;
    req_if.opcode  <= OP_WRITE;
    req_if.index   <= '0;
    req_if.start_x <= '0;
    req_if.start_y <= '0;
    req_if.end_x   <= '0;
    req_if.end_y   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With wall_count at its reset value of zero, no wall is
    // tested, so even a path across the whole plane is clear.
    send_item(item_of(OP_QUERY, 63, -32768, -32768, 32767, 32767));
    // Wall 0 is a short horizontal wall, wall 1 a vertical one, wall 63 runs
    // between opposite corners of the coordinate range.
    send_item(item_of(OP_WRITE, 0, -256, 0, 256, 0));
    send_item(item_of(OP_WRITE, 63, 32767, -32768, -32768, 32767));
    send_item(item_of(OP_WRITE, 1, 512, -512, 512, 512));
    write_wall_count(2);
    // Vertical path through the middle of wall 0.
    send_item(item_of(OP_QUERY, 0, 0, -256, 0, 256));
    // Path that only touches the end of wall 0.
    send_item(item_of(OP_QUERY, 0, 256, 0, 256, 512));
    // Parallel to wall 0, one half unit above it.
    send_item(item_of(OP_QUERY, 0, -256, 128, 256, 128));
    // Collinear with wall 0 and overlapping it.
    send_item(item_of(OP_QUERY, 0, -128, 0, 128, 0));
    // Zero-length path lying on wall 0.
    send_item(item_of(OP_QUERY, 0, 0, 0, 0, 0));
    // Vertical and collinear with wall 1, reaching past both of its ends.
    send_item(item_of(OP_QUERY, 0, 512, -1024, 512, 1024));
    // Vertical path that misses the end of wall 0 by one LSB.
    send_item(item_of(OP_QUERY, 0, 257, -256, 257, 256));
    // Diagonal path through wall 1, in the opposite sense as well.
    send_item(item_of(OP_QUERY, 0, 0, -512, 1024, 512));
    send_item(item_of(OP_QUERY, 0, 1024, 512, 0, -512));
    // Wall 0 shrinks to a point, which no path can cross.
    send_item(item_of(OP_WRITE, 0, 0, 0, 0, 0));
    send_item(item_of(OP_QUERY, 0, -256, 0, 256, 0));
    // Full-range diagonal that grazes the top end of wall 1.
    send_item(item_of(OP_QUERY, 0, -32768, -32768, 32767, 32767));
    send_item(item_of(OP_QUERY, 0, 32767, -32768, -32768, 32767));

    // Random phases. Phase 0 keeps wall_count at one and fills the table in
    // index order; every later phase may then test any number of walls.
    fill_next = 1;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      count = (ph == 8 || ph == 9) ? COUNT_W'($urandom_range(127, 0))
                                   : COUNT_W'(PHASE_COUNTS[ph]);
      write_wall_count(count);
      sender_calm   = (ph % 4 == 3);
      receiver_calm = (ph % 4 == 2);
      for (int k = 0; k < PHASE_ITEMS || fill_next < WALL_SLOTS; k++) begin
        if (fill_next < WALL_SLOTS && $urandom_range(3, 0) != 0) begin
          item.op  = OP_WRITE;
          item.idx = INDEX_W'(fill_next);
          fill_next++;
        end else begin
          item.op  = ($urandom_range(99, 0) < 30) ? OP_WRITE : OP_QUERY;
          item.idx = INDEX_W'($urandom());
        end
        item.seg = (item.op == OP_WRITE) ? make_segment() : make_path();
        send_item(item);
        // Now and then the sender holds off until the block has run dry.
        if ($urandom_range(63, 0) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
